/* src/ewc_pkg.sv */
// Shared types and constants for the edge trigger window capture block.
`default_nettype none
package ewc_pkg;

	localparam int unsigned SAMPLE_W  = 16;
	localparam int unsigned ANALOG_W  = 10;
	localparam int unsigned ANALOG_LSB = 6;
	localparam int unsigned DIGITAL_N = 6;
	localparam int unsigned INDEX_W   = 32;
	localparam int unsigned WIN_W     = 17;
	localparam int unsigned PRE_W     = 16;
	localparam int unsigned SRC_W     = 3;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = 17;
	localparam logic [WIN_W-1:0] WIN_MIN   = 17'd2;
	localparam logic [WIN_W-1:0] WIN_LIMIT = 17'd65536;

	localparam logic [CFG_IDX_W-1:0] CFG_SOURCE  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RISING  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LEVEL   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_PRETRIG = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_SINGLE  = 3'd5;

	localparam logic [SRC_W-1:0] SRC_ANALOG = 3'd0;
	localparam logic [SRC_W-1:0] SRC_UNUSED = 3'd7;

	localparam logic REQ_SAMPLE = 1'b0;
	localparam logic REQ_REARM  = 1'b1;

	typedef struct packed {
		logic                req_type;
		logic [SAMPLE_W-1:0] sample;
	} in_word_t;

	typedef struct packed {
		logic               trigger_seen;
		logic               window_ready;
		logic [INDEX_W-1:0] window_start;
		logic [INDEX_W-1:0] trigger_index;
		logic               is_holding;
	} out_word_t;

	// register values as seen by the trigger logic, window and pretrigger already clamped
	typedef struct packed {
		logic [SRC_W-1:0]    source;
		logic                rising;
		logic [ANALOG_W-1:0] level;
		logic [PRE_W-1:0]    pretrig;
		logic [PRE_W-1:0]    post;
		logic                single;
	} cfg_view_t;

endpackage
`default_nettype wire

/* src/ewc_cfg.sv */
// Configuration registers and clamped window / pretrigger lengths.
`default_nettype none
module ewc_cfg import ewc_pkg::*; #(
	parameter int unsigned MAX_WINDOW = 65536
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_view_t                  cfg
);

	localparam logic [WIN_W-1:0] WIN_CAP = (MAX_WINDOW < 65536) ?
		WIN_W'(MAX_WINDOW) : WIN_LIMIT;

	logic [SRC_W-1:0]    source_q;
	logic                rising_q;
	logic [ANALOG_W-1:0] level_q;
	logic [WIN_W-1:0]    window_q;
	logic [PRE_W-1:0]    pretrig_q;
	logic                single_q;

	logic [WIN_W-1:0] win_eff;
	logic [WIN_W-1:0] pre_eff;
	logic [WIN_W-1:0] post_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			source_q  <= SRC_ANALOG;
			rising_q  <= 1'b1;
			level_q   <= 10'd512;
			window_q  <= 17'd1024;
			pretrig_q <= 16'd512;
			single_q  <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SOURCE:  source_q  <= cfg_data[SRC_W-1:0];
				CFG_RISING:  rising_q  <= cfg_data[0];
				CFG_LEVEL:   level_q   <= cfg_data[ANALOG_W-1:0];
				CFG_WINDOW:  window_q  <= cfg_data[WIN_W-1:0];
				CFG_PRETRIG: pretrig_q <= cfg_data[PRE_W-1:0];
				CFG_SINGLE:  single_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		win_eff = window_q;
		if (win_eff < WIN_MIN) win_eff = WIN_MIN;
		if (win_eff > WIN_CAP) win_eff = WIN_CAP;
		pre_eff = {1'b0, pretrig_q};
		if (pre_eff > win_eff - 17'd1) pre_eff = win_eff - 17'd1;
		post_eff = win_eff - pre_eff - 17'd1;
	end

	assign cfg.source  = source_q;
	assign cfg.rising  = rising_q;
	assign cfg.level   = level_q;
	assign cfg.pretrig = pre_eff[PRE_W-1:0];
	assign cfg.post    = post_eff[PRE_W-1:0];
	assign cfg.single  = single_q;

endmodule
`default_nettype wire

/* src/ewc_edge.sv */
// Edge detector: analog threshold crossing or digital line transition.
`default_nettype none
module ewc_edge import ewc_pkg::*; (
	input  cfg_view_t                cfg,
	input  wire logic [SAMPLE_W-1:0] prev,
	input  wire logic [SAMPLE_W-1:0] curr,
	output logic                     hit
);

	logic [ANALOG_W-1:0] a_prev;
	logic [ANALOG_W-1:0] a_curr;
	logic [SRC_W-1:0]    bit_sel;
	logic                d_prev;
	logic                d_curr;

	assign a_prev  = prev[ANALOG_LSB +: ANALOG_W];
	assign a_curr  = curr[ANALOG_LSB +: ANALOG_W];
	assign bit_sel = cfg.source - 3'd1;

	always_comb begin
		d_prev = 1'b0;
		d_curr = 1'b0;
		for (int i = 0; i < DIGITAL_N; i++) begin
			if (bit_sel == SRC_W'(i)) begin
				d_prev = prev[i];
				d_curr = curr[i];
			end
		end
		priority if (cfg.source == SRC_ANALOG) begin
			if (cfg.rising) hit = (a_prev < cfg.level) && (a_curr >= cfg.level);
			else            hit = (a_prev > cfg.level) && (a_curr <= cfg.level);
		end else if (cfg.source == SRC_UNUSED) begin
			hit = 1'b0;
		end else begin
			if (cfg.rising) hit = !d_prev && d_curr;
			else            hit = d_prev && !d_curr;
		end
	end

endmodule
`default_nettype wire

/* src/ewc_core.sv */
// Trigger state: eligibility, posttrigger count, hold, result word.
`default_nettype none
module ewc_core import ewc_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   en,
	input  in_word_t    word,
	input  cfg_view_t   cfg,
	output out_word_t   result
);

	logic [SAMPLE_W-1:0] prev_q;
	logic                have_prev_q;
	logic [INDEX_W-1:0]  index_q;
	logic                pending_q;
	logic [INDEX_W-1:0]  trig_q;
	logic [PRE_W-1:0]    remain_q;
	logic                hold_q;

	logic [SAMPLE_W-1:0] prev_d;
	logic                have_prev_d;
	logic [INDEX_W-1:0]  index_d;
	logic                pending_d;
	logic [INDEX_W-1:0]  trig_d;
	logic [PRE_W-1:0]    remain_d;
	logic                hold_d;
	logic [PRE_W-1:0]    remain_dec;
	logic                edge_hit;
	logic                seen;
	logic                ready;
	logic [INDEX_W-1:0]  start;
	logic [INDEX_W-1:0]  pre_ext;

	ewc_edge u_edge (
		.cfg  (cfg),
		.prev (prev_q),
		.curr (word.sample),
		.hit  (edge_hit)
	);

	assign pre_ext    = {{(INDEX_W-PRE_W){1'b0}}, cfg.pretrig};
	assign remain_dec = (remain_q != '0) ? remain_q - 16'd1 : remain_q;

	always_comb begin
		prev_d      = prev_q;
		have_prev_d = have_prev_q;
		index_d     = index_q;
		pending_d   = pending_q;
		trig_d      = trig_q;
		remain_d    = remain_q;
		hold_d      = hold_q;
		seen        = 1'b0;
		ready       = 1'b0;
		start       = '0;
		if (word.req_type == REQ_REARM) begin
			hold_d = 1'b0;
		end else begin
			if (pending_q) begin
				remain_d = remain_dec;
				if (remain_dec == '0) begin
					pending_d = 1'b0;
					ready     = 1'b1;
					start     = trig_q - pre_ext;
					if (cfg.single) hold_d = 1'b1;
				end
			end else if (have_prev_q && !hold_q && (index_q >= pre_ext) && edge_hit) begin
				seen   = 1'b1;
				trig_d = index_q;
				if (cfg.post == '0) begin
					ready = 1'b1;
					start = index_q - pre_ext;
					if (cfg.single) hold_d = 1'b1;
				end else begin
					pending_d = 1'b1;
					remain_d  = cfg.post;
				end
			end
			prev_d      = word.sample;
			have_prev_d = 1'b1;
			index_d     = index_q + 32'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q      <= '0;
			have_prev_q <= 1'b0;
			index_q     <= '0;
			pending_q   <= 1'b0;
			trig_q      <= '0;
			remain_q    <= '0;
			hold_q      <= 1'b0;
		end else if (en) begin
			prev_q      <= prev_d;
			have_prev_q <= have_prev_d;
			index_q     <= index_d;
			pending_q   <= pending_d;
			trig_q      <= trig_d;
			remain_q    <= remain_d;
			hold_q      <= hold_d;
		end
	end

	assign result.trigger_seen  = seen;
	assign result.window_ready  = ready;
	assign result.window_start  = start;
	assign result.trigger_index = trig_d;
	assign result.is_holding    = hold_d;

endmodule
`default_nettype wire

/* src/edge_trigger_window_capture_top.sv */
// Top level of the edge trigger window capture block.
//
//  channel | direction | handshake         | payload
//  --------+-----------+-------------------+------------------------------
//  in      | in        | in_valid/in_stall | in_word_t  (req_type, sample)
//  out     | out       | out_valid/out_stall | out_word_t (one per word)
//  cfg     | in        | cfg_we            | cfg_index, cfg_data
//
// One word a cycle sustained while the output is not stalled; a result passes
// through the input register, then the result register behind the trigger
// logic, before it is valid at the output.
// Reset clears registers to their defaults and all trigger state at once.
// A stalled result holds the result register; the input register still takes
// a word, and in_stall rises only when both registers are full.
`default_nettype none
module edge_trigger_window_capture_top import ewc_pkg::*; #(
	parameter int unsigned MAX_WINDOW = 65536
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  in_word_t                   in_data,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output out_word_t                  out_data,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_view_t cfg;
	in_word_t  word_s1;
	logic      valid_q;
	out_word_t result;
	out_word_t result_s2;
	logic      out_valid_q;
	logic      advance;

	ewc_cfg #(
		.MAX_WINDOW (MAX_WINDOW)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	ewc_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (advance),
		.word   (word_s1),
		.cfg    (cfg),
		.result (result)
	);

	assign advance  = valid_q && (!out_valid_q || !out_stall);
	assign in_stall = valid_q && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!in_stall) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) word_s1 <= in_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) result_s2 <= result;
	end

	assign out_valid = out_valid_q;
	assign out_data  = result_s2;

endmodule
`default_nettype wire

/* test/testbench.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the edge trigger window capture block: directed and random words.
module testbench;
	import ewc_pkg::*;

	localparam int unsigned MAX_WIN = 65536;
	localparam int HOLD_OFF_CYCLES = 300;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	in_word_t              in_data;
	logic                  out_valid;
	logic                  out_stall;
	out_word_t             out_data;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int hold_off_left  = 0;
	int fail_count     = 0;

	out_word_t window_reports[$];

	// predicted registers
	logic [SRC_W-1:0]    cfg_source  = SRC_ANALOG;
	logic                cfg_rising  = 1'b1;
	logic [ANALOG_W-1:0] cfg_level   = 10'd512;
	logic [WIN_W-1:0]    cfg_window  = 17'd1024;
	logic [PRE_W-1:0]    cfg_pretrig = 16'd512;
	logic                cfg_single  = 1'b0;

	// predicted trigger state
	logic [SAMPLE_W-1:0] prev_word       = '0;
	logic                prev_known      = 1'b0;
	logic [INDEX_W-1:0]  next_index      = '0;
	logic                capture_pending = 1'b0;
	logic [INDEX_W-1:0]  capture_at      = '0;
	logic [PRE_W-1:0]    post_left       = '0;
	logic                holding         = 1'b0;

	edge_trigger_window_capture_top #(
		.MAX_WINDOW(MAX_WIN)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic logic [31:0] eff_window();
		logic [31:0] w;
		w = cfg_window;
		if (w < 2) w = 2;
		if (w > MAX_WIN) w = MAX_WIN;
		if (w > 65536) w = 65536;
		return w;
	endfunction

	function automatic logic [31:0] eff_pretrig();
		logic [31:0] w;
		logic [31:0] p;
		w = eff_window();
		p = cfg_pretrig;
		if (p > w - 1) p = w - 1;
		return p;
	endfunction

	function automatic logic edge_hit(input logic [SAMPLE_W-1:0] was, input logic [SAMPLE_W-1:0] now);
		logic [ANALOG_W-1:0] a;
		logic [ANALOG_W-1:0] b;
		int unsigned bitpos;
		if (cfg_source == SRC_ANALOG) begin
			a = was[ANALOG_LSB +: ANALOG_W];
			b = now[ANALOG_LSB +: ANALOG_W];
			if (cfg_rising)
				return a < cfg_level && b >= cfg_level;
			return a > cfg_level && b <= cfg_level;
		end
		if (cfg_source == SRC_UNUSED)
			return 1'b0;
		bitpos = cfg_source - 1;
		if (cfg_rising)
			return !was[bitpos] && now[bitpos];
		return was[bitpos] && !now[bitpos];
	endfunction

	function automatic out_word_t capture_predict(input in_word_t w);
		out_word_t r;
		logic [31:0] idx;
		logic [31:0] p;
		logic [31:0] post;
		r = '0;
		if (w.req_type == REQ_REARM) begin
			holding = 1'b0;
		end else begin
			idx = next_index;
			p = eff_pretrig();
			if (capture_pending) begin
				if (post_left > 0) post_left = post_left - 1'b1;
				if (post_left == 0) begin
					capture_pending = 1'b0;
					r.window_ready = 1'b1;
					r.window_start = capture_at - p;
					if (cfg_single) holding = 1'b1;
				end
			end else if (prev_known && !holding && idx >= p && edge_hit(prev_word, w.sample)) begin
				post = eff_window() - p - 1;
				r.trigger_seen = 1'b1;
				capture_at = idx;
				if (post == 0) begin
					r.window_ready = 1'b1;
					r.window_start = idx - p;
					if (cfg_single) holding = 1'b1;
				end else begin
					capture_pending = 1'b1;
					post_left = post[PRE_W-1:0];
				end
			end
			prev_word = w.sample;
			prev_known = 1'b1;
			next_index = idx + 1;
		end
		r.trigger_index = capture_at;
		r.is_holding = holding;
		return r;
	endfunction

	function automatic void take_config(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		case (idx)
			CFG_SOURCE:  cfg_source  = data[SRC_W-1:0];
			CFG_RISING:  cfg_rising  = data[0];
			CFG_LEVEL:   cfg_level   = data[ANALOG_W-1:0];
			CFG_WINDOW:  cfg_window  = data[WIN_W-1:0];
			CFG_PRETRIG: cfg_pretrig = data[PRE_W-1:0];
			CFG_SINGLE:  cfg_single  = data[0];
			default: ;
		endcase
	endfunction

	function automatic in_word_t sample_word(input logic [ANALOG_W-1:0] analog,
			input logic [DIGITAL_N-1:0] dig);
		in_word_t r;
		r.req_type = REQ_SAMPLE;
		r.sample = {analog, dig};
		return r;
	endfunction

	function automatic in_word_t rearm_word();
		in_word_t r;
		r.req_type = REQ_REARM;
		r.sample = 16'($urandom);
		return r;
	endfunction

	function automatic in_word_t random_word();
		int a;
		if ($urandom_range(19) == 0)
			return rearm_word();
		case ($urandom_range(9))
			0, 1, 2, 3: a = int'(cfg_level) + int'($urandom_range(2)) - 1;
			4:          a = $urandom_range(1) ? 1023 : 0;
			default:    a = $urandom_range(1023);
		endcase
		if (a < 0) a = 0;
		if (a > 1023) a = 1023;
		return sample_word(10'(a), 6'($urandom));
	endfunction

	// receiver: random stall, or a long hold-off when requested
	always @(negedge clk) begin
		if (hold_off_left > 0) begin
			out_stall <= 1'b1;
			hold_off_left = hold_off_left - 1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	task automatic report(input string name, input logic [31:0] want, input logic [31:0] got);
		$error("%s expected %0d, got %0d", name, want, got);
		fail_count++;
	endtask

	always @(posedge clk) begin : check_results
		out_word_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (window_reports.size() == 0) begin
				$error("result word with nothing expected");
				fail_count++;
			end else begin
				want = window_reports.pop_front();
				if (out_data.trigger_seen !== want.trigger_seen)
					report("trigger_seen", want.trigger_seen, out_data.trigger_seen);
				if (out_data.window_ready !== want.window_ready)
					report("window_ready", want.window_ready, out_data.window_ready);
				if (out_data.window_start !== want.window_start)
					report("window_start", want.window_start, out_data.window_start);
				if (out_data.trigger_index !== want.trigger_index)
					report("trigger_index", want.trigger_index, out_data.trigger_index);
				if (out_data.is_holding !== want.is_holding)
					report("is_holding", want.is_holding, out_data.is_holding);
			end
		end
	end

	task automatic send_word(input in_word_t w);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= w;
		do @(posedge clk); while (in_stall);
		window_reports.push_back(capture_predict(w));
	endtask

	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (window_reports.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		take_config(idx, data);
	endtask

	task automatic configure(input logic [SRC_W-1:0] src, input logic rising,
			input logic [ANALOG_W-1:0] level, input logic [WIN_W-1:0] win,
			input logic [PRE_W-1:0] pre, input logic single);
		settle();
		write_reg(CFG_SOURCE, CFG_DATA_W'(src));
		write_reg(CFG_RISING, CFG_DATA_W'(rising));
		write_reg(CFG_LEVEL, CFG_DATA_W'(level));
		write_reg(CFG_WINDOW, CFG_DATA_W'(win));
		write_reg(CFG_PRETRIG, CFG_DATA_W'(pre));
		write_reg(CFG_SINGLE, CFG_DATA_W'(single));
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic random_configure();
		logic [WIN_W-1:0]    win;
		logic [PRE_W-1:0]    pre;
		logic [ANALOG_W-1:0] lvl;
		case ($urandom_range(9))
			0: begin
				win = 17'h1FFFF;
				pre = 16'hFFFF;
			end
			1: begin
				win = 17'($urandom_range(1));
				pre = 16'($urandom_range(3));
			end
			default: begin
				win = 17'($urandom_range(24, 2));
				pre = 16'($urandom_range(win + 2));
			end
		endcase
		case ($urandom_range(3))
			0:       lvl = '0;
			1:       lvl = 10'h3FF;
			default: lvl = 10'($urandom);
		endcase
		configure(3'($urandom_range(7)), 1'($urandom), lvl, win, pre, 1'($urandom));
	endtask

	// reset registers: crossings of the 512 level stay blind below index 512
	task automatic test_reset_defaults();
		for (int i = 0; i < 40; i++)
			send_word(sample_word((i % 2) ? 10'd512 : 10'd511, 6'($urandom)));
	endtask

	task automatic test_analog_edges();
		configure(SRC_ANALOG, 1'b1, 10'h3FF, 17'd2, 16'd0, 1'b0);
		send_word(sample_word(10'd0, 6'($urandom)));
		send_word(sample_word(10'h3FF, 6'($urandom)));
		send_word(sample_word(10'h3FE, 6'($urandom)));
		send_word(sample_word(10'h3FF, 6'($urandom)));
		send_word(sample_word(10'h3FF, 6'($urandom)));
		configure(SRC_ANALOG, 1'b0, 10'd0, 17'd2, 16'd0, 1'b0);
		send_word(sample_word(10'h3FF, 6'($urandom)));
		send_word(sample_word(10'd0, 6'($urandom)));
		send_word(sample_word(10'd1, 6'($urandom)));
		send_word(sample_word(10'd0, 6'($urandom)));
		configure(SRC_ANALOG, 1'b0, 10'd512, 17'd2, 16'd0, 1'b0);
		send_word(sample_word(10'd513, 6'($urandom)));
		send_word(sample_word(10'd512, 6'($urandom)));
	endtask

	task automatic test_digital_edges();
		configure(3'd3, 1'b1, 10'd512, 17'd2, 16'd0, 1'b0);
		send_word(sample_word(10'($urandom), 6'h00));
		send_word(sample_word(10'($urandom), 6'h04));
		send_word(sample_word(10'($urandom), 6'h00));
		configure(3'd6, 1'b0, 10'd512, 17'd2, 16'd0, 1'b0);
		send_word(sample_word(10'($urandom), 6'h20));
		send_word(sample_word(10'($urandom), 6'h00));
		send_word(sample_word(10'($urandom), 6'h3F));
		// unused source never fires, whatever toggles
		configure(SRC_UNUSED, 1'b1, 10'd512, 17'd2, 16'd0, 1'b0);
		send_word(sample_word(10'h000, 6'h00));
		send_word(sample_word(10'h3FF, 6'h3F));
		send_word(sample_word(10'h000, 6'h00));
		send_word(sample_word(10'h3FF, 6'h3F));
	endtask

	task automatic test_short_window();
		// window 0 acts as 2, pretrigger 5 clamps to 1: ready on the trigger word
		configure(3'd1, 1'b1, 10'd512, 17'd0, 16'd5, 1'b0);
		send_word(sample_word(10'($urandom), 6'h00));
		send_word(sample_word(10'($urandom), 6'h01));
		configure(3'd1, 1'b1, 10'd512, 17'd1, 16'd0, 1'b0);
		send_word(sample_word(10'($urandom), 6'h00));
		send_word(sample_word(10'($urandom), 6'h01));
		send_word(sample_word(10'($urandom), 6'h00));
	endtask

	task automatic test_reconfig_while_pending();
		configure(3'd1, 1'b1, 10'd512, 17'd10, 16'd2, 1'b0);
		send_word(sample_word(10'($urandom), 6'h00));
		send_word(sample_word(10'($urandom), 6'h01));
		for (int i = 0; i < 3; i++)
			send_word(sample_word(10'($urandom), 6'($urandom)));
		configure(3'd1, 1'b1, 10'd512, 17'd3, 16'd1, 1'b0);
		for (int i = 0; i < 6; i++)
			send_word(sample_word(10'($urandom), 6'($urandom)));
	endtask

	task automatic test_single_hold();
		configure(3'd1, 1'b1, 10'd512, 17'd2, 16'd0, 1'b1);
		send_word(sample_word(10'($urandom), 6'h00));
		send_word(sample_word(10'($urandom), 6'h01));
		send_word(sample_word(10'($urandom), 6'h00));
		send_word(sample_word(10'($urandom), 6'h01));
		// hold survives clearing single mode
		configure(3'd1, 1'b1, 10'd512, 17'd2, 16'd0, 1'b0);
		send_word(sample_word(10'($urandom), 6'h00));
		send_word(sample_word(10'($urandom), 6'h01));
		send_word(rearm_word());
		send_word(sample_word(10'($urandom), 6'h00));
		send_word(sample_word(10'($urandom), 6'h01));
		send_word(sample_word(10'($urandom), 6'h00));
		// rearm while a capture is pending leaves it alone
		configure(3'd1, 1'b1, 10'd512, 17'd2, 16'd0, 1'b1);
		send_word(sample_word(10'($urandom), 6'h01));
		send_word(rearm_word());
		send_word(sample_word(10'($urandom), 6'h00));
		send_word(rearm_word());
	endtask

	// saturated window opens a posttrigger wait far longer than the rest of the run
	task automatic test_long_window();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		configure(3'd1, 1'b1, 10'd512, 17'h1FFFF, 16'd0, 1'b0);
		send_word(sample_word(10'($urandom), 6'h00));
		send_word(sample_word(10'($urandom), 6'h01));
		for (int i = 0; i < 8; i++)
			send_word(sample_word(10'($urandom), 6'($urandom)));
	endtask

	task automatic test_full_pretrig();
		configure(3'd1, 1'b1, 10'd512, 17'h1FFFF, 16'hFFFF, 1'b0);
		send_word(sample_word(10'($urandom), 6'h00));
		send_word(sample_word(10'($urandom), 6'h01));
		send_word(sample_word(10'($urandom), 6'h00));
	endtask

	task automatic test_back_pressure();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		configure(SRC_ANALOG, 1'b1, 10'd512, 17'd4, 16'd1, 1'b0);
		@(posedge clk);
		hold_off_left = HOLD_OFF_CYCLES;
		for (int i = 0; i < 60; i++)
			send_word(random_word());
	endtask

	task automatic test_random_phase(input int send_pct, input int recv_pct, input int items);
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
		for (int n = 0; n < items; n++) begin
			if (n % 75 == 0) random_configure();
			send_word(random_word());
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_stall = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_idle_pct = 30;
		recv_stall_pct = 30;
		test_reset_defaults();
		test_analog_edges();
		test_digital_edges();
		test_short_window();
		test_reconfig_while_pending();
		test_single_hold();
		test_full_pretrig();
		test_back_pressure();
		test_random_phase(0, 0, 175);
		test_random_phase(70, 0, 175);
		test_random_phase(0, 70, 175);
		test_random_phase(16, 16, 175);
		test_long_window();

		settle();
		repeat (10) @(posedge clk);
		if (fail_count == 0 && window_reports.size() == 0) begin
			$display("edge_trigger_window_capture_top verification clean");
		end else begin
			$display("edge_trigger_window_capture_top verification failed");
		end
		$finish;
	end

	initial begin
		#10ms;
		$display("edge_trigger_window_capture_top verification failed");
		$finish;
	end

endmodule

/* filelist.f */
src/ewc_pkg.sv
src/ewc_cfg.sv
src/ewc_edge.sv
src/ewc_core.sv
src/edge_trigger_window_capture_top.sv
test/testbench.sv
